@@ rtl/pkcs1_pkg.sv @@
`timescale 1ns / 1ps
package pkcs1_pkg;

  localparam int DEF_MAX_BLOCK_BYTES = 512;
  localparam int DEF_WORD_BYTES      = 8;

  localparam int OVERHEAD_BYTES  = 11;
  localparam int MIN_BLOCK_BYTES = 12;
  // separator may not sit before this position (at least 8 padding bytes)
  localparam int MIN_SEP_POS     = 10;

  localparam logic [7:0]  PAD_FF     = 8'hff;
  localparam logic [7:0]  BT_RANDOM  = 8'd2;
  localparam logic [7:0]  BT_FF      = 8'd1;
  localparam logic [31:0] LFSR_POLY  = 32'hD000_0001;
  localparam logic [31:0] LFSR_DEF   = 32'd1;

  localparam logic [1:0] FUNC_DATA   = 2'd0;
  localparam logic [1:0] FUNC_FINISH = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  localparam logic [1:0] CFG_DIRECTION   = 2'd0;
  localparam logic [1:0] CFG_KEY_KIND    = 2'd1;
  localparam logic [1:0] CFG_BLOCK_BYTES = 2'd2;
  localparam logic [1:0] CFG_SEED        = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_SCAN,
    ST_EMIT,
    ST_STATUS
  } state_e;

  typedef struct packed {
    logic start;
    logic write_byte;
    logic close_blk;
    logic set_err;
    logic stat_arm;
    logic stat_fail;
    logic stat_push;
    logic fwd_step;
    logic scan;
    logic scan_to_emit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic fill_zero;
    logic full_after;
    logic fwd_last;
    logic scan_done;
    logic scan_ok;
    logic scan_empty;
    logic emit_done;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] lfsr_fwd8(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ LFSR_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // exact inverse of lfsr_fwd8: the feedback bit lands in bit 31
  function automatic logic [31:0] lfsr_back8(input logic [31:0] v);
    logic [31:0] r;
    r = v;
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? (((r ^ LFSR_POLY) << 1) | 32'd1) : (r << 1);
    end
    return r;
  endfunction

endpackage

@@ rtl/pkcs1_ram.sv @@
`timescale 1ns / 1ps
module pkcs1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pkcs1_ctrl.sv @@
`timescale 1ns / 1ps
module pkcs1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic              dir_i,
  input  logic              key_i,
  input  pkcs1_pkg::stat_t  stat_i,
  output pkcs1_pkg::cmd_t   cmd_o
);
  import pkcs1_pkg::*;

  state_e state_q, state_d;
  logic   take;

  assign take = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take && (func_i == FUNC_DATA || func_i == FUNC_FINISH)) begin
          if (stat_i.err) begin
            state_d = ST_STATUS;
          end else if ((func_i == FUNC_DATA && stat_i.full_after) ||
                       (func_i == FUNC_FINISH && !stat_i.fill_zero && !dir_i)) begin
            state_d = dir_i ? ST_SCAN : (key_i ? ST_FWD : ST_EMIT);
          end else if (func_i == FUNC_FINISH && !stat_i.fill_zero) begin
            state_d = ST_STATUS;
          end
        end
      end
      ST_FWD: begin
        if (stat_i.fwd_last) state_d = ST_EMIT;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = (!stat_i.scan_ok || stat_i.scan_empty) ? ST_STATUS : ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.emit_done) state_d = ST_IDLE;
      end
      ST_STATUS: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (take) begin
          if (func_i == FUNC_START) begin
            cmd_o.start = 1'b1;
          end else if (func_i == FUNC_DATA || func_i == FUNC_FINISH) begin
            if (stat_i.err) begin
              cmd_o.stat_arm  = 1'b1;
              cmd_o.stat_fail = 1'b1;
            end else if (func_i == FUNC_DATA) begin
              cmd_o.write_byte = 1'b1;
              cmd_o.close_blk  = stat_i.full_after;
            end else if (!stat_i.fill_zero) begin
              if (dir_i) begin
                // partial block on decode
                cmd_o.set_err   = 1'b1;
                cmd_o.stat_arm  = 1'b1;
                cmd_o.stat_fail = 1'b1;
              end else begin
                cmd_o.close_blk = 1'b1;
              end
            end
          end
        end
      end
      ST_FWD: cmd_o.fwd_step = 1'b1;
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          if (!stat_i.scan_ok) begin
            cmd_o.set_err   = 1'b1;
            cmd_o.stat_arm  = 1'b1;
            cmd_o.stat_fail = 1'b1;
          end else if (stat_i.scan_empty) begin
            cmd_o.stat_arm  = 1'b1;
          end else begin
            cmd_o.scan_to_emit = 1'b1;
          end
        end
      end
      ST_EMIT: cmd_o.emit = 1'b1;
      ST_STATUS: cmd_o.stat_push = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/pkcs1_dp.sv @@
`timescale 1ns / 1ps
module pkcs1_dp #(
  parameter int MAX_BLOCK_BYTES = pkcs1_pkg::DEF_MAX_BLOCK_BYTES,
  parameter int WORD_BYTES      = pkcs1_pkg::DEF_WORD_BYTES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pkcs1_pkg::cmd_t   cmd_i,
  output pkcs1_pkg::stat_t  stat_o,
  input  logic              dir_i,
  input  logic              key_i,
  input  logic [9:0]        block_bytes_i,
  input  logic [31:0]       seed_i,
  input  logic [7:0]        data_byte_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [63:0]       out_word_o,
  output logic [3:0]        out_count_o,
  output logic              block_end_o,
  output logic              failed_o
);
  import pkcs1_pkg::*;

  localparam int PW = $clog2(MAX_BLOCK_BYTES + 1);
  localparam int AW = $clog2(MAX_BLOCK_BYTES);
  localparam logic [PW-1:0] OVH    = PW'(OVERHEAD_BYTES);
  localparam logic [PW-1:0] RUNMIN = PW'(MIN_SEP_POS);
  localparam logic [3:0]    WLAST  = 4'(WORD_BYTES - 1);

  // effective block size
  logic [10:0]   bbw;
  logic [PW-1:0] size, size_m1, maxd;

  always_comb begin
    bbw = {1'b0, block_bytes_i};
    if (bbw < 11'(MIN_BLOCK_BYTES)) begin
      size = PW'(MIN_BLOCK_BYTES);
    end else if (bbw > 11'(MAX_BLOCK_BYTES)) begin
      size = PW'(MAX_BLOCK_BYTES);
    end else begin
      size = bbw[PW-1:0];
    end
  end
  assign size_m1 = size - PW'(1);
  assign maxd    = size - OVH;

  logic [PW-1:0] fill_q, fill_d;
  logic          err_q, err_d;
  logic [31:0]   lfsr_q, lfsr_d;
  logic [31:0]   work_q, work_d;
  logic [PW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          rd_pend_q, rd_pend_d;
  logic [PW-1:0] rd_pos_q, rd_pos_d;
  logic [PW-1:0] offset_q, offset_d;
  logic [PW-1:0] sep_q, sep_d;
  logic          emit_dec_q, emit_dec_d;
  logic          ok_q, ok_d;
  logic [63:0]   word_q, word_d;
  logic [3:0]    wcnt_q, wcnt_d;
  logic          stat_fail_q, stat_fail_d;
  logic          out_valid_q, out_valid_d;
  logic [63:0]   out_word_q, out_word_d;
  logic [3:0]    out_count_q, out_count_d;
  logic          out_end_q, out_end_d;
  logic          out_fail_q, out_fail_d;

  logic [PW-1:0] fill_lim, fill_new, fill_eff, dlen;
  logic          fill_inc;
  logic          out_free;

  assign fill_lim = dir_i ? size : maxd;
  assign fill_inc = fill_q < fill_lim;
  assign fill_new = fill_q + PW'(fill_inc);
  assign fill_eff = cmd_i.write_byte ? fill_new : fill_q;
  assign dlen     = (fill_eff < maxd) ? fill_eff : maxd;
  assign out_free = !out_valid_q || out_ready_i;

  // store
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    rbyte;
  logic [PW-1:0] waddr_full, raddr_full;

  assign waddr_full = dir_i ? fill_q : fill_q + OVH;
  assign ram_we     = cmd_i.write_byte && fill_inc;
  assign ram_waddr  = waddr_full[AW-1:0];

  pkcs1_ram #(
    .WIDTH(8),
    .DEPTH(MAX_BLOCK_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(data_byte_i),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rbyte)
  );

  // read sequencing
  logic last, wdone, take, scan_iss, emit_iss;
  assign last     = rd_pos_q == size_m1;
  assign wdone    = (wcnt_q == WLAST) || last;
  assign take     = cmd_i.emit && rd_pend_q && (!wdone || out_free);
  assign scan_iss = cmd_i.scan && (pos_q < size);
  assign emit_iss = cmd_i.emit && (pos_q < size) && (!rd_pend_q || take);
  assign ram_re   = scan_iss || emit_iss;
  assign raddr_full = (cmd_i.scan || emit_dec_q) ? pos_q : pos_q - offset_q;
  assign ram_raddr  = raddr_full[AW-1:0];

  // byte of the block at rd_pos_q
  logic [7:0] pad_byte, ebyte;
  logic       in_pad;
  assign pad_byte = (work_q[7:0] == 8'd0) ? 8'd1 : work_q[7:0];
  assign in_pad   = (rd_pos_q >= PW'(2)) && (rd_pos_q < sep_q);

  always_comb begin
    if (emit_dec_q) begin
      ebyte = rbyte;
    end else if (rd_pos_q == PW'(0)) begin
      ebyte = 8'd0;
    end else if (rd_pos_q == PW'(1)) begin
      ebyte = key_i ? BT_RANDOM : BT_FF;
    end else if (in_pad) begin
      ebyte = key_i ? pad_byte : PAD_FF;
    end else if (rd_pos_q == sep_q) begin
      ebyte = 8'd0;
    end else begin
      ebyte = rbyte;
    end
  end

  logic [63:0] word_ins;
  logic [5:0]  shamt;
  assign shamt    = 6'd56 - {wcnt_q[2:0], 3'b000};
  assign word_ins = word_q | ({56'd0, ebyte} << shamt);

  // separator scan on decode
  logic scan_dat, is0, is1, run, found, exhausted, scan_done;
  logic [7:0] exp_bt;
  assign scan_dat  = cmd_i.scan && rd_pend_q;
  assign is0       = rd_pos_q == PW'(0);
  assign is1       = rd_pos_q == PW'(1);
  assign exp_bt    = key_i ? BT_FF : BT_RANDOM;
  assign run       = key_i ? (rbyte == PAD_FF) : (rbyte != 8'd0);
  assign found     = !is0 && !is1 && !run;
  assign exhausted = !is0 && !is1 && run && last;
  assign scan_done = scan_dat && (found || exhausted);

  always_comb begin
    stat_o            = '0;
    stat_o.err        = err_q;
    stat_o.fill_zero  = fill_q == '0;
    stat_o.full_after = fill_new >= fill_lim;
    stat_o.fwd_last   = cnt_q == PW'(1);
    stat_o.scan_done  = scan_done;
    stat_o.scan_ok    = found && ok_q && (rd_pos_q >= RUNMIN) && (rbyte == 8'd0);
    stat_o.scan_empty = last;
    stat_o.emit_done  = take && last;
    stat_o.out_free   = out_free;
  end

  always_comb begin
    fill_d      = fill_q;
    err_d       = err_q;
    lfsr_d      = lfsr_q;
    work_d      = work_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    rd_pend_d   = rd_pend_q;
    rd_pos_d    = rd_pos_q;
    offset_d    = offset_q;
    sep_d       = sep_q;
    emit_dec_d  = emit_dec_q;
    ok_d        = ok_q;
    word_d      = word_q;
    wcnt_d      = wcnt_q;
    stat_fail_d = stat_fail_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    out_count_d = out_count_q;
    out_end_d   = out_end_q;
    out_fail_d  = out_fail_q;

    if (cmd_i.start) begin
      fill_d = '0;
      err_d  = 1'b0;
      lfsr_d = (seed_i == 32'd0) ? LFSR_DEF : seed_i;
    end
    if (cmd_i.write_byte) fill_d = fill_new;
    if (cmd_i.close_blk) begin
      fill_d     = '0;
      cnt_d      = size - dlen - PW'(3);
      offset_d   = size - dlen - OVH;
      sep_d      = size - dlen - PW'(1);
      pos_d      = '0;
      rd_pend_d  = 1'b0;
      emit_dec_d = dir_i;
      ok_d       = 1'b1;
      word_d     = '0;
      wcnt_d     = '0;
    end
    if (cmd_i.set_err)  err_d = 1'b1;
    if (cmd_i.stat_arm) stat_fail_d = cmd_i.stat_fail;

    // padding LFSR runs ahead to its final state, then back down per byte
    if (cmd_i.fwd_step) begin
      lfsr_d = lfsr_fwd8(lfsr_q);
      cnt_d  = cnt_q - PW'(1);
      if (cnt_q == PW'(1)) work_d = lfsr_fwd8(lfsr_q);
    end

    if (ram_re) begin
      pos_d     = pos_q + PW'(1);
      rd_pos_d  = pos_q;
      rd_pend_d = 1'b1;
    end else if (take || cmd_i.scan) begin
      rd_pend_d = 1'b0;
    end

    if (scan_dat) begin
      if (is0) ok_d = ok_q && (rbyte == 8'd0);
      if (is1) ok_d = ok_q && (rbyte == exp_bt);
    end
    if (cmd_i.scan_to_emit) begin
      pos_d     = rd_pos_q + PW'(1);
      rd_pend_d = 1'b0;
    end

    if (take) begin
      if (!emit_dec_q && key_i && in_pad) work_d = lfsr_back8(work_q);
      if (wdone) begin
        out_valid_d = 1'b1;
        out_word_d  = word_ins;
        out_count_d = wcnt_q + 4'd1;
        out_end_d   = last;
        out_fail_d  = 1'b0;
        word_d      = '0;
        wcnt_d      = '0;
      end else begin
        word_d = word_ins;
        wcnt_d = wcnt_q + 4'd1;
      end
    end

    if (cmd_i.stat_push && out_free) begin
      out_valid_d = 1'b1;
      out_word_d  = '0;
      out_count_d = '0;
      out_end_d   = 1'b1;
      out_fail_d  = stat_fail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      err_q       <= 1'b0;
      lfsr_q      <= LFSR_DEF;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      wcnt_q      <= '0;
      word_q      <= '0;
    end else begin
      fill_q      <= fill_d;
      err_q       <= err_d;
      lfsr_q      <= lfsr_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      wcnt_q      <= wcnt_d;
      word_q      <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q      <= work_d;
    cnt_q       <= cnt_d;
    pos_q       <= pos_d;
    rd_pos_q    <= rd_pos_d;
    offset_q    <= offset_d;
    sep_q       <= sep_d;
    emit_dec_q  <= emit_dec_d;
    ok_q        <= ok_d;
    stat_fail_q <= stat_fail_d;
    out_word_q  <= out_word_d;
    out_count_q <= out_count_d;
    out_end_q   <= out_end_d;
    out_fail_q  <= out_fail_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;
  assign out_count_o = out_count_q;
  assign block_end_o = out_end_q;
  assign failed_o    = out_fail_q;

endmodule

@@ rtl/pkcs1_block_pad_unpad.sv @@
`timescale 1ns / 1ps
// PKCS#1 v1.5 block framer (no modular exponentiation). Encode collects data
// bytes and emits 00 BT PS 00 DATA as MSB-first words; decode collects a full
// block, checks its padding and emits the data bytes or a sticky failure
// status. A data byte that does not close a block leaves the framer ready
// for the next item. Closing an encode block with random padding first
// advances the LFSR once per padding byte, then reads and packs one block
// byte per cycle from the byte store; type 1 padding skips the LFSR pass.
// Closing a decode block scans the store one byte per cycle up to the
// separator, then emits the remaining bytes at one per cycle. Output stalls
// hold the packer.
module pkcs1_block_pad_unpad #(
  parameter int MAX_BLOCK_BYTES = pkcs1_pkg::DEF_MAX_BLOCK_BYTES,
  parameter int WORD_BYTES      = pkcs1_pkg::DEF_WORD_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_count_o,
  output logic        block_end_o,
  output logic        failed_o
);
  import pkcs1_pkg::*;

  logic        dir_q, key_q;
  logic [9:0]  bb_q;
  logic [31:0] seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      key_q  <= 1'b1;
      bb_q   <= 10'd256;
      seed_q <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIRECTION:   dir_q  <= cfg_wdata_i[0];
        CFG_KEY_KIND:    key_q  <= cfg_wdata_i[0];
        CFG_BLOCK_BYTES: bb_q   <= cfg_wdata_i[9:0];
        CFG_SEED:        seed_q <= cfg_wdata_i;
        default:         dir_q  <= dir_q;
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;

  pkcs1_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .func_i    (func_i),
    .dir_i     (dir_q),
    .key_i     (key_q),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pkcs1_dp #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES),
    .WORD_BYTES     (WORD_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .dir_i        (dir_q),
    .key_i        (key_q),
    .block_bytes_i(bb_q),
    .seed_i       (seed_q),
    .data_byte_i  (data_byte_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_count_o  (out_count_o),
    .block_end_o  (block_end_o),
    .failed_o     (failed_o)
  );

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import pkcs1_pkg::*;

  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int WATCH_LIMIT = 20000;
  localparam int MAX_BLK = 512;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  count;
    logic        last;
    logic        fail;
  } word_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_DATA;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] out_word_o;
  logic [3:0]  out_count_o;
  logic        block_end_o;
  logic        failed_o;

  pkcs1_block_pad_unpad uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic        p_dir;
  logic        p_kind;
  logic [9:0]  p_size;
  logic [31:0] p_seed;
  logic [7:0]  p_mem [MAX_BLK];
  int unsigned p_fill;
  logic        p_err;
  logic [31:0] p_lfsr;

  word_beat_t  pending_words [$];
  int          fail_cnt = 0;
  bit          quiet_mode = 0;   // no idling on either side
  int          rx_hold = 0;      // long receiver stall request
  bit          any_beat;

  function automatic int unsigned block_len();
    int unsigned s;
    s = p_size;
    if (s < MIN_BLOCK_BYTES) s = MIN_BLOCK_BYTES;
    if (s > MAX_BLK) s = MAX_BLK;
    return s;
  endfunction

  function automatic logic [7:0] pad_byte();
    for (int k = 0; k < 8; k++)
      p_lfsr = p_lfsr[0] ? ((p_lfsr >> 1) ^ 32'hD000_0001) : (p_lfsr >> 1);
    return (p_lfsr[7:0] == 8'd0) ? 8'd1 : p_lfsr[7:0];
  endfunction

  function automatic void push_status(logic fail);
    word_beat_t b;
    b.word = '0; b.count = '0; b.last = 1'b1; b.fail = fail;
    pending_words.push_back(b);
  endfunction

  function automatic void push_bytes(logic [7:0] bytes [$]);
    int unsigned pos, cnt;
    word_beat_t b;
    if (bytes.size() == 0) begin
      push_status(1'b0);
      return;
    end
    pos = 0;
    while (pos < bytes.size()) begin
      cnt = bytes.size() - pos;
      if (cnt > 8) cnt = 8;
      b.word = '0;
      for (int j = 0; j < cnt; j++) b.word[63 - 8*j -: 8] = bytes[pos + j];
      pos += cnt;
      b.count = 4'(cnt);
      b.last = (pos >= bytes.size());
      b.fail = 1'b0;
      pending_words.push_back(b);
    end
  endfunction

  function automatic void pad_block(int unsigned d);
    logic [7:0] blk [$];
    int unsigned s;
    s = block_len();
    for (int i = 0; i < s; i++) blk.push_back(8'd0);
    for (int i = 0; i < d; i++) blk[s - d + i] = p_mem[OVERHEAD_BYTES + i];
    if (p_kind) begin
      blk[1] = BT_RANDOM;
      for (int i = s - d - 2; i >= 2; i--) blk[i] = pad_byte();
    end else begin
      blk[1] = BT_FF;
      for (int i = 2; i < s - d - 1; i++) blk[i] = PAD_FF;
    end
    p_fill = 0;
    push_bytes(blk);
  endfunction

  function automatic void strip_block();
    logic [7:0] data [$];
    int unsigned s, i;
    bit ok;
    s = block_len();
    i = 2;
    ok = (p_mem[0] == 8'd0);
    p_fill = 0;
    if (p_kind) begin
      if (p_mem[1] != BT_FF) ok = 0;
      while (i < s && p_mem[i] == PAD_FF) i++;
    end else begin
      if (p_mem[1] != BT_RANDOM) ok = 0;
      while (i < s && p_mem[i] != 8'd0) i++;
    end
    if (i < MIN_SEP_POS || i >= s || p_mem[i] != 8'd0) ok = 0;
    if (!ok) begin
      p_err = 1'b1;
      push_status(1'b1);
      return;
    end
    for (int k = i + 1; k < s; k++) data.push_back(p_mem[k]);
    push_bytes(data);
  endfunction

  function automatic void predict_item(logic [1:0] f, logic [7:0] b);
    int unsigned s, maxd;
    s = block_len();
    if (f == FUNC_START) begin
      p_fill = 0; p_err = 1'b0;
      p_lfsr = (p_seed == 0) ? 32'd1 : p_seed;
      return;
    end
    if (f == FUNC_NOP) return;
    if (p_err) begin
      push_status(1'b1);
      return;
    end
    if (!p_dir) begin
      maxd = s - OVERHEAD_BYTES;
      if (f == FUNC_DATA) begin
        if (p_fill < maxd) begin
          p_mem[OVERHEAD_BYTES + p_fill] = b;
          p_fill++;
        end
        if (p_fill >= maxd) pad_block(maxd);
      end else if (p_fill != 0) begin
        pad_block(p_fill < maxd ? p_fill : maxd);
      end
      return;
    end
    if (f == FUNC_DATA) begin
      if (p_fill < s) begin
        p_mem[p_fill] = b;
        p_fill++;
      end
      if (p_fill >= s) strip_block();
    end else if (p_fill != 0) begin
      p_err = 1'b1;
      push_status(1'b1);
    end
  endfunction

  // ---------------- sender side ----------------
  task automatic send_item(logic [1:0] f, logic [7:0] b);
    if (!quiet_mode && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    data_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(f, b);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DIRECTION:   p_dir  = val[0];
      CFG_KEY_KIND:    p_kind = val[0];
      CFG_BLOCK_BYTES: p_size = val[9:0];
      default:         p_seed = val;
    endcase
  endtask

  task automatic setup(logic dir, logic kind, logic [9:0] sz, logic [31:0] seed);
    wait_idle();
    write_reg(CFG_DIRECTION, 32'(dir));
    write_reg(CFG_KEY_KIND, 32'(kind));
    write_reg(CFG_BLOCK_BYTES, 32'(sz));
    write_reg(CFG_SEED, seed);
    send_item(FUNC_START, 8'($urandom));
  endtask

  // well-formed block for the current key kind, optionally damaged
  task automatic send_padded(bit damage);
    logic [7:0] blk [$];
    int unsigned s, plen;
    s = block_len();
    plen = $urandom_range(8, s - 3);
    if ($urandom_range(3) == 0) plen = 8;
    blk.push_back(8'd0);
    blk.push_back(p_kind ? BT_FF : BT_RANDOM);
    for (int i = 0; i < plen; i++) blk.push_back(p_kind ? PAD_FF : 8'($urandom_range(1, 255)));
    blk.push_back(8'd0);
    while (blk.size() < s) blk.push_back(8'($urandom));
    if (damage) blk[$urandom_range(0, 12 < s ? 12 : s - 1)] = 8'($urandom);
    foreach (blk[i]) send_item(FUNC_DATA, blk[i]);
  endtask

  // ---------------- receiver side ----------------
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= quiet_mode || ($urandom_range(99) >= 20);
    end
  end

  always @(posedge clk_i) begin
    word_beat_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected result beat word=%h count=%0d", out_word_o, out_count_o);
        fail_cnt++;
      end else begin
        e = pending_words.pop_front();
        if (out_word_o !== e.word) begin
          $error("out_word exp %h got %h", e.word, out_word_o); fail_cnt++;
        end
        if (out_count_o !== e.count) begin
          $error("out_count exp %0d got %0d", e.count, out_count_o); fail_cnt++;
        end
        if (block_end_o !== e.last) begin
          $error("block_end exp %b got %b", e.last, block_end_o); fail_cnt++;
        end
        if (failed_o !== e.fail) begin
          $error("failed exp %b got %b", e.fail, failed_o); fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any accepted beat
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_encode_directed();
    // reset values: encode, random padding, 256-byte block, seed 1
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_DATA, 8'hff);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_FINISH, 8'h00);          // empty finish
    send_item(FUNC_NOP, 8'hff);
    setup(1'b0, 1'b0, 10'd12, 32'h0);       // one data byte per block, zero seed
    send_item(FUNC_DATA, 8'h5a);
    setup(1'b0, 1'b1, 10'd0, 32'hffff_ffff); // below minimum size
    send_item(FUNC_DATA, 8'ha5);
    setup(1'b0, 1'b1, 10'd1023, 32'h1234_5678); // above maximum size
    send_item(FUNC_DATA, 8'h81);
    send_item(FUNC_FINISH, 8'h00);
    setup(1'b0, 1'b0, 10'd512, 32'd7);
    send_item(FUNC_DATA, 8'h7e);
    send_item(FUNC_FINISH, 8'h00);
  endtask

  task automatic test_decode_directed();
    setup(1'b1, 1'b1, 10'd24, 32'd1);
    send_padded(0);
    setup(1'b1, 1'b0, 10'd24, 32'd1);
    send_padded(0);
    // separator as last byte: empty data
    for (int i = 0; i < 24; i++)
      send_item(FUNC_DATA, i == 0 ? 8'd0 : i == 1 ? BT_RANDOM : i == 23 ? 8'd0 : 8'h33);
    // padding run too short
    for (int i = 0; i < 24; i++)
      send_item(FUNC_DATA, i == 0 ? 8'd0 : i == 1 ? BT_RANDOM : i == 6 ? 8'd0 : 8'h44);
    send_item(FUNC_DATA, 8'h11);            // refused
    send_item(FUNC_FINISH, 8'h00);          // refused
    send_item(FUNC_START, 8'h00);
    send_item(FUNC_DATA, 8'h00);
    send_item(FUNC_FINISH, 8'h00);          // partial block
    send_item(FUNC_START, 8'h00);
  endtask

  task automatic test_shrink_midblock();
    setup(1'b0, 1'b1, 10'd30, 32'hace1);
    for (int i = 0; i < 10; i++) send_item(FUNC_DATA, 8'($urandom));
    wait_idle();
    write_reg(CFG_BLOCK_BYTES, 32'd12);
    send_item(FUNC_DATA, 8'hee);            // dropped, block closes
    setup(1'b1, 1'b1, 10'd30, 32'd1);
    for (int i = 0; i < 20; i++)
      send_item(FUNC_DATA, i == 0 ? 8'd0 : i == 1 ? BT_FF : i < 10 ? PAD_FF :
                           i == 10 ? 8'd0 : 8'($urandom));
    wait_idle();
    write_reg(CFG_BLOCK_BYTES, 32'd12);
    send_item(FUNC_DATA, 8'h99);
  endtask

  task automatic test_backpressure();
    setup(1'b0, 1'b0, 10'd12, 32'd1);
    quiet_mode = 1;
    rx_hold = 400;
    for (int i = 0; i < 30; i++) send_item(FUNC_DATA, 8'($urandom));
    wait_idle();                             // sender pauses until all results are in
    quiet_mode = 0;
  endtask

  task automatic test_random();
    int items, n;
    items = 0;
    while (items < 130) begin
      setup(1'($urandom_range(1)), 1'($urandom_range(1)),
            ($urandom_range(19) == 0) ? 10'($urandom_range(0, 1023))
                                      : 10'($urandom_range(12, 40)),
            $urandom);
      quiet_mode = ($urandom_range(7) == 0);
      repeat ($urandom_range(1, 3)) begin
        if (p_dir) begin
          if (block_len() > 60) begin
            send_item(FUNC_DATA, 8'($urandom));
            send_item(FUNC_FINISH, 8'($urandom));
            items += 2;
          end else begin
            send_padded($urandom_range(4) == 0);
            items += block_len();
          end
        end else begin
          n = $urandom_range(0, block_len() - OVERHEAD_BYTES + 2);
          if (n > 40) n = 3;
          for (int i = 0; i < n; i++) send_item(FUNC_DATA, 8'($urandom));
          items += n;
        end
        case ($urandom_range(5))
          0: send_item(FUNC_START, 8'($urandom));
          1: send_item(FUNC_NOP, 8'($urandom));
          2: begin
            send_item(FUNC_DATA, 8'($urandom));
            items++;
          end
          default: begin
            send_item(FUNC_FINISH, 8'($urandom));
            items++;
          end
        endcase
      end
      quiet_mode = 0;
    end
  endtask

  initial begin
    p_dir = 1'b0; p_kind = 1'b1; p_size = 10'd256; p_seed = 32'd1;
    p_fill = 0; p_err = 1'b0; p_lfsr = 32'd1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_encode_directed();
    test_decode_directed();
    test_shrink_midblock();
    test_backpressure();
    test_random();
    wait_idle();
    repeat (100) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
